/* src/oli_pkg.sv */
// Shared codes and types for the ordered list block.
// No dependencies; the list module and the cell import this package.
package oli_pkg;

    typedef logic [2:0] t_func;
    typedef logic [1:0] t_status;
    typedef logic [2:0] t_cell_op;

    // input operation codes
    localparam t_func FUNC_APPEND = 3'd0;
    localparam t_func FUNC_INSERT = 3'd1;
    localparam t_func FUNC_DELETE = 3'd2;
    localparam t_func FUNC_READ   = 3'd3;
    localparam t_func FUNC_CLEAR  = 3'd4;

    // result status codes
    localparam t_status STAT_OK       = 2'd0;
    localparam t_status STAT_FULL     = 2'd1;
    localparam t_status STAT_NOTFOUND = 2'd2;
    localparam t_status STAT_EMPTY    = 2'd3;

    // per-cycle command broadcast to every cell
    localparam t_cell_op OP_HOLD  = 3'd0;
    localparam t_cell_op OP_MATCH = 3'd1;
    localparam t_cell_op OP_INS   = 3'd2;
    localparam t_cell_op OP_DEL   = 3'd3;
    localparam t_cell_op OP_ROT   = 3'd4;

endpackage

/* src/oli_if.sv */
// Valid/ready channel interfaces for the ordered list block.
// Depends on nothing; field widths are fixed by the block's item format.
interface oli_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] key;
    logic signed [31:0] value;

    modport source (output valid, func, key, value, input ready);
    modport sink   (input valid, func, key, value, output ready);
endinterface

interface oli_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [3:0]         position;
    logic               last;

    modport source (output valid, status, element, position, last, input ready);
    modport sink   (input valid, status, element, position, last, output ready);
endinterface

/* src/ordered_list_insert_delete.sv */
// Ordered list of up to DEPTH values, kept in a row of cells, entry 0 first.
//
// Channels: i_in takes one command per transfer (func, key, value); o_out
// gives results (status, element, position, last). Both are valid/ready.
// Append and clear pass the execute state to their result; insert and delete
// pass a match state first, for the cells to register their key compare. A
// read out gives one result per cycle while o_out is not stalled: the row
// rotates by one slot per result and is back in order after the last one. The
// sequencer handles one command at a time; the next command is taken as soon
// as the previous one's final result sits in the output register.
// Reset empties the list (count to zero); entry contents are not cleared.
// A stalled receiver holds the output register and the sequencer waits;
// unknown func codes are taken and dropped without a result.
module ordered_list_insert_delete
    import oli_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    oli_in_if.sink    i_in,
    oli_out_if.source o_out
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_READ  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [IW-1:0]         r_rpos,  n_rpos;
    t_func                 r_func;
    logic [VALUE_BITS-1:0] r_key, r_value;

    logic                  r_ovalid, n_ovalid;
    t_status               r_status, n_status;
    logic [31:0]           r_element, n_element;
    logic [3:0]            r_position, n_position;
    logic                  r_last, n_last;

    logic [VALUE_BITS-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]      w_hit, w_first;
    logic [DEPTH:0]        w_before;
    logic [IW-1:0]         w_enc, w_pos;
    t_cell_op              w_op;
    logic                  w_slot, w_accept, w_full, w_rlast;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_slot   = !r_ovalid || o_out.ready;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_rlast  = ((CW'(r_rpos) + CW'(1)) == r_count);

    // first-match search: running OR passed along the row
    assign w_before[0] = 1'b0;
    for (genvar g = 0; g < DEPTH; g++) begin : g_chain
        assign w_before[g+1] = w_before[g] | w_hit[g];
        assign w_first[g]    = w_hit[g] & ~w_before[g];

        oli_cell #(
            .VALUE_BITS(VALUE_BITS),
            .IW        (IW),
            .CW        (CW),
            .IDX       (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_op   (w_op),
            .i_pos  (w_pos),
            .i_count(r_count),
            .i_key  (r_key),
            .i_value(r_value),
            .i_left ((g == 0) ? '0 : w_data[(g == 0) ? 0 : g-1]),
            .i_right((g == DEPTH-1) ? '0 : w_data[(g == DEPTH-1) ? g : g+1]),
            .i_head (w_data[0]),
            .o_data (w_data[g]),
            .o_hit  (w_hit[g])
        );
    end

    always_comb begin
        w_enc = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_enc = w_enc | (w_first[i] ? IW'(i) : '0);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rpos     = r_rpos;
        n_ovalid   = r_ovalid && !o_out.ready;
        n_status   = r_status;
        n_element  = r_element;
        n_position = r_position;
        n_last     = r_last;
        w_op       = OP_HOLD;
        w_pos      = r_count[IW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.func == FUNC_INSERT || i_in.func == FUNC_DELETE) begin
                        n_state = S_MATCH;
                    end else if (i_in.func <= FUNC_CLEAR) begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_MATCH: begin
                w_op    = OP_MATCH;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_slot) begin
                    n_ovalid   = 1'b1;
                    n_status   = STAT_OK;
                    n_element  = '0;
                    n_position = '0;
                    n_last     = 1'b1;
                    n_state    = S_IDLE;
                    case (r_func)
                        FUNC_APPEND, FUNC_INSERT: begin
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                if (r_func == FUNC_INSERT && w_before[DEPTH]) begin
                                    w_pos = w_enc;
                                end
                                w_op       = OP_INS;
                                n_count    = r_count + CW'(1);
                                n_position = 4'(w_pos);
                            end
                        end
                        FUNC_DELETE: begin
                            if (!w_before[DEPTH]) begin
                                n_status = STAT_NOTFOUND;
                            end else begin
                                w_pos      = w_enc;
                                w_op       = OP_DEL;
                                n_count    = r_count - CW'(1);
                                n_position = 4'(w_enc);
                            end
                        end
                        FUNC_READ: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_ovalid = r_ovalid && !o_out.ready;
                                n_rpos   = '0;
                                n_state  = S_READ;
                            end
                        end
                        default: n_count = '0;
                    endcase
                end
            end
            S_READ: begin
                if (w_slot) begin
                    w_op       = OP_ROT;
                    n_ovalid   = 1'b1;
                    n_status   = STAT_OK;
                    n_element  = 32'(w_data[0]);
                    n_position = 4'(r_rpos);
                    n_last     = w_rlast;
                    n_rpos     = r_rpos + IW'(1);
                    if (w_rlast) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rpos     <= n_rpos;
        r_status   <= n_status;
        r_element  <= n_element;
        r_position <= n_position;
        r_last     <= n_last;
        if (w_accept) begin
            r_func  <= i_in.func;
            r_key   <= VALUE_BITS'(i_in.key);
            r_value <= VALUE_BITS'(i_in.value);
        end
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ovalid;
    assign o_out.status   = r_status;
    assign o_out.element  = r_element;
    assign o_out.position = r_position;
    assign o_out.last     = r_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list count above depth");

    // hit flags are only meaningful once a compare has been registered
    a_first_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && (r_func == FUNC_INSERT || r_func == FUNC_DELETE))
        |-> $onehot0(w_first))
        else $error("more than one first match");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> r_count != '0)
        else $error("read out of empty list");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && w_slot && w_full &&
         (r_func == FUNC_APPEND || r_func == FUNC_INSERT))
        |=> (r_count == $past(r_count) && o_out.valid && o_out.status == STAT_FULL))
        else $error("full list changed on refused store");

    a_read_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && w_slot && w_rlast) |=> (r_state == S_IDLE && o_out.last))
        else $error("read out did not end on last entry");

endmodule

/* src/oli_cell.sv */
// One list slot: holds an entry, compares it against the key and moves data
// to or from its neighbours. Depends on oli_pkg.
module oli_cell
    import oli_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int IW         = 4,
    parameter int CW         = 5,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [IW-1:0]         i_pos,
    input  logic [CW-1:0]         i_count,
    input  logic [VALUE_BITS-1:0] i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [VALUE_BITS-1:0] i_left,
    input  logic [VALUE_BITS-1:0] i_right,
    input  logic [VALUE_BITS-1:0] i_head,
    output logic [VALUE_BITS-1:0] o_data,
    output logic                  o_hit
);

    localparam logic [IW-1:0] IDX_P  = IW'(IDX);
    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_C1 = CW'(IDX + 1);

    logic [VALUE_BITS-1:0] r_data, n_data;
    logic                  r_hit,  n_hit;

    always_comb begin
        n_data = r_data;
        n_hit  = r_hit;
        case (i_op)
            OP_MATCH: n_hit = (IDX_C < i_count) && (r_data == i_key);
            OP_INS: begin
                if (IDX_P == i_pos) begin
                    n_data = i_value;
                end else if (IDX_P > i_pos) begin
                    n_data = i_left;
                end
            end
            OP_DEL: begin
                if (IDX_P >= i_pos) begin
                    n_data = i_right;
                end
            end
            OP_ROT: begin
                // tail slot takes the head, the rest move down by one
                if (IDX_C1 == i_count) begin
                    n_data = i_head;
                end else if (IDX_C1 < i_count) begin
                    n_data = i_right;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_hit  <= n_hit;
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule
